@@ hw/rtl/abod_pkg.sv @@
// Shared types and constants of the beat onset detector.
package abod_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_CUT_MODE       = 2'd0;
   localparam logic [1:0] CSR_CUT_MIN_DELAY  = 2'd1;
   localparam logic [1:0] CSR_CUT_BASS_THR   = 2'd2;
   localparam logic [1:0] CSR_CUT_TREBLE_THR = 2'd3;

   // Hard cut rules
   localparam logic [1:0] CUT_BASS   = 2'd0;
   localparam logic [1:0] CUT_TREBLE = 2'd1;
   localparam logic [1:0] CUT_BOTH   = 2'd2;
   localparam logic [1:0] CUT_EITHER = 2'd3;

   // Register reset values
   localparam logic [1:0]  CUT_MODE_RST       = CUT_BASS;
   localparam logic [15:0] CUT_MIN_DELAY_RST  = 16'd1000;
   localparam logic [15:0] CUT_BASS_THR_RST   = 16'd256;
   localparam logic [8:0]  CUT_TREBLE_THR_RST = 9'd128;

   // Fixed-point constants
   localparam logic [15:0] STRENGTH_ONE = 16'd32768;
   localparam logic [15:0] BPM_MAX      = 16'hFFFF;
   localparam logic [19:0] BPM_SCALE    = 20'd960000;
   localparam logic [8:0]  TREBLE_CAP   = 9'd256;
   localparam int          DIV_QUOT_W   = 16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_EVAL,
      ST_DIV_STR,
      ST_SOFT_CHK,
      ST_BEAT_WR,
      ST_WALK,
      ST_BPM_CHK,
      ST_DIV_BPM,
      ST_FINISH
   } abod_state_type;

   typedef struct packed {
      logic capture;
      logic update;
      logic eval;
      logic take_str;
      logic beat_wr;
      logic walk;
      logic bpm_chk;
      logic take_bpm;
      logic finish;
   } abod_cmd_type;

   typedef struct packed {
      logic need_div;
      logic onset;
      logic beat_any;
      logic walk_last;
      logic bpm_div;
      logic div_done;
      logic out_free;
   } abod_status_type;

endpackage

@@ hw/rtl/abod_div.sv @@
// Restoring divider, one quotient bit per cycle.
module abod_div #(
   parameter int DW = 40
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] hi,
   input  logic [15:0]   lo,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [15:0]   quot
);
   import abod_pkg::*;

   localparam int CNTW = $clog2(DIV_QUOT_W);

   logic [DW-1:0]   rem_ff, den_ff;
   logic [15:0]     lo_ff, quot_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff, done_ff;
   logic [DW:0]     trial;
   logic            ge;
   logic [DW:0]     diff;

   // Shift in the next dividend bit and try to subtract
   assign trial = {rem_ff, lo_ff[15]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(DIV_QUOT_W - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= hi;
         lo_ff   <= lo;
         den_ff  <= den;
         quot_ff <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[DW-1:0] : trial[DW-1:0];
         lo_ff   <= {lo_ff[14:0], 1'b0};
         quot_ff <= {quot_ff[14:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

@@ hw/rtl/abod_dp.sv @@
// Datapath: history rings, threshold tests, tempo and hard cut logic.
module abod_dp #(
   parameter int BASS_RING_DEPTH = 64,
   parameter int BEAT_RING_DEPTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  abod_pkg::abod_cmd_type    cmd,
   output abod_pkg::abod_status_type status,
   input  logic [15:0]               req_bass_level,
   input  logic [15:0]               req_treble_level,
   input  logic [15:0]               req_bass_attenuated,
   input  logic [31:0]               req_frame_time_ms,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [15:0]               rsp_beat_strength,
   output logic                      rsp_soft_beat,
   output logic                      rsp_hard_cut,
   output logic [15:0]               rsp_tempo_bpm,
   input  logic                      csr_valid,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata
);
   import abod_pkg::*;

   localparam int BPW   = $clog2(BASS_RING_DEPTH);
   localparam int FILLW = $clog2(BASS_RING_DEPTH + 1);
   localparam int SUMW  = 16 + BPW;
   localparam int NUMW  = 16 + FILLW;
   localparam int TPW   = $clog2(BEAT_RING_DEPTH);
   localparam int CW    = $clog2(BEAT_RING_DEPTH + 1);
   localparam int NW    = $clog2(BEAT_RING_DEPTH);
   localparam int TW    = 32 + NW;
   localparam int PW    = 20 + NW;
   localparam int DW    = (SUMW + 2 > TW) ? SUMW + 2 : TW;

   // Configuration registers
   logic [1:0]  cut_mode_ff;
   logic [15:0] cut_min_delay_ff, cut_bass_thr_ff;
   logic [8:0]  cut_treble_thr_ff;

   // Captured request
   logic [15:0] bass_ff, treble_ff, battn_ff;
   logic [31:0] now_ff;

   // Bass history
   logic [15:0]      bass_mem [BASS_RING_DEPTH];
   logic [15:0]      bass_rd_ff;
   logic [BPW-1:0]   ptr_ff;
   logic [FILLW-1:0] filled_ff, filled_in;
   logic [SUMW-1:0]  sum_ff;
   logic [15:0]      prev_ff, old_bass;
   logic [NUMW-1:0]  num_ff;
   logic             full;

   // Threshold tests
   logic [SUMW+1:0] sum3;
   logic [SUMW+4:0] num5, sum9;
   logic [19:0]     bass10, prev13;
   logic            sum_zero, sat, soft_now, soft_ff;
   logic [15:0]     strength_ff;

   // Beat history
   logic [31:0]    beat_mem [BEAT_RING_DEPTH];
   logic [31:0]    beat_rd_ff, prev_t_ff, t_diff;
   logic [TPW-1:0] bptr_ff, idx_ff, idx_in;
   logic [CW-1:0]  count_ff, k_ff;
   logic [TW-1:0]  total_ff;
   logic [NW-1:0]  n_ff;
   logic [15:0]    held_ff;
   logic [PW-1:0]  bpm_prod;
   logic           bpm_sat;

   // Hard cut
   logic [31:0] last_cut_ff, elapsed;
   logic        cut_seen_ff;
   logic [17:0] treble3;
   logic [8:0]  treble_n;
   logic        b_hit, t_hit, rule_hit, cut_now;

   // Divider hookup
   logic          div_start, div_done;
   logic [DW-1:0] div_hi, div_den;
   logic [15:0]   div_lo, div_quot;

   // Output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_strength_ff, rsp_bpm_ff;
   logic        rsp_soft_ff, rsp_cut_ff;

   function automatic logic [TPW-1:0] beat_dec(input logic [TPW-1:0] i);
      return (i == '0) ? TPW'(BEAT_RING_DEPTH - 1) : i - 1'b1;
   endfunction

   // Accept configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cut_mode_ff       <= CUT_MODE_RST;
         cut_min_delay_ff  <= CUT_MIN_DELAY_RST;
         cut_bass_thr_ff   <= CUT_BASS_THR_RST;
         cut_treble_thr_ff <= CUT_TREBLE_THR_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CUT_MODE:       cut_mode_ff       <= csr_wdata[1:0];
            CSR_CUT_MIN_DELAY:  cut_min_delay_ff  <= csr_wdata;
            CSR_CUT_BASS_THR:   cut_bass_thr_ff   <= csr_wdata;
            CSR_CUT_TREBLE_THR: cut_treble_thr_ff <= csr_wdata[8:0];
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         bass_ff   <= req_bass_level;
         treble_ff <= req_treble_level;
         battn_ff  <= req_bass_attenuated;
         now_ff    <= req_frame_time_ms;
      end
   end

   // Bass ring memory; an entry counts once the ring has wrapped
   always_ff @(posedge clock) begin
      if (cmd.update)
         bass_mem[ptr_ff] <= bass_ff;
      bass_rd_ff <= bass_mem[ptr_ff];
   end

   assign full      = filled_ff == FILLW'(BASS_RING_DEPTH);
   assign old_bass  = full ? bass_rd_ff : 16'd0;
   assign filled_in = full ? filled_ff : filled_ff + 1'b1;

   // Advance the ring, running sum and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         filled_ff <= '0;
         sum_ff    <= '0;
      end else if (cmd.update) begin
         ptr_ff    <= (ptr_ff == BPW'(BASS_RING_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;
         filled_ff <= filled_in;
         sum_ff    <= sum_ff - SUMW'(old_bass) + SUMW'(bass_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update)
         num_ff <= NUMW'(bass_ff) * NUMW'(filled_in);
   end

   // Strength saturation and onset tests
   assign sum3     = ({2'b0, sum_ff} << 1) + {2'b0, sum_ff};
   assign sum_zero = sum_ff == '0;
   assign sat      = (SUMW + 3)'({num_ff, 1'b0}) >= (SUMW + 3)'(sum3);
   assign num5     = ((SUMW + 5)'(num_ff) << 2) + (SUMW + 5)'(num_ff);
   assign sum9     = ((SUMW + 5)'(sum_ff) << 3) + (SUMW + 5)'(sum_ff);
   assign bass10   = ({4'b0, bass_ff} << 3) + ({4'b0, bass_ff} << 1);
   assign prev13   = ({4'b0, prev_ff} << 3) + ({4'b0, prev_ff} << 2) + {4'b0, prev_ff};
   assign soft_now = !sum_zero && (num5 > sum9) && (bass10 > prev13);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
         soft_ff <= 1'b0;
      end else if (cmd.eval) begin
         prev_ff <= bass_ff;
         soft_ff <= soft_now;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         if (sum_zero)
            strength_ff <= '0;
         else if (sat)
            strength_ff <= STRENGTH_ONE;
      end else if (cmd.take_str && div_done) begin
         strength_ff <= div_quot;
      end
   end

   // Beat timestamp ring with registered read
   always_comb begin
      priority if (cmd.beat_wr)
         idx_in = beat_dec(bptr_ff);
      else if (cmd.walk)
         idx_in = beat_dec(idx_ff);
      else
         idx_in = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.beat_wr)
         beat_mem[bptr_ff] <= now_ff;
      beat_rd_ff <= beat_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bptr_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.beat_wr) begin
         bptr_ff <= (bptr_ff == TPW'(BEAT_RING_DEPTH - 1)) ? '0 : bptr_ff + 1'b1;
         if (count_ff != CW'(BEAT_RING_DEPTH))
            count_ff <= count_ff + 1'b1;
      end
   end

   // Walk back over stored beats and sum nonzero intervals
   assign t_diff = prev_t_ff - beat_rd_ff;

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.beat_wr) begin
         prev_t_ff <= now_ff;
         k_ff      <= '0;
         total_ff  <= '0;
         n_ff      <= '0;
      end else if (cmd.walk) begin
         prev_t_ff <= beat_rd_ff;
         k_ff      <= k_ff + 1'b1;
         if (t_diff != '0) begin
            total_ff <= total_ff + TW'(t_diff);
            n_ff     <= n_ff + 1'b1;
         end
      end
   end

   // Tempo: 960000*n over total, saturated
   assign bpm_prod = PW'(BPM_SCALE) * PW'(n_ff);
   assign bpm_sat  = DW'(bpm_prod[PW-1:16]) >= DW'(total_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (cmd.bpm_chk && n_ff != '0 && bpm_sat) begin
         held_ff <= BPM_MAX;
      end else if (cmd.take_bpm && div_done) begin
         held_ff <= div_quot;
      end
   end

   // Shared divider
   assign div_start = (cmd.eval && !sum_zero && !sat) ||
                      (cmd.bpm_chk && n_ff != '0 && !bpm_sat);
   assign div_hi    = cmd.bpm_chk ? DW'(bpm_prod[PW-1:16]) : DW'(num_ff);
   assign div_lo    = cmd.bpm_chk ? bpm_prod[15:0] : 16'd0;
   assign div_den   = cmd.bpm_chk ? DW'(total_ff) : DW'(sum3);

   abod_div #(.DW(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .hi    (div_hi),
      .lo    (div_lo),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Hard cut rule and hold-off
   assign treble3  = ({2'b0, treble_ff} << 1) + {2'b0, treble_ff};
   assign treble_n = (treble3 > 18'(TREBLE_CAP)) ? TREBLE_CAP : treble3[8:0];
   assign b_hit    = battn_ff > cut_bass_thr_ff;
   assign t_hit    = treble_n > cut_treble_thr_ff;
   assign elapsed  = now_ff - last_cut_ff;

   always_comb begin
      unique case (cut_mode_ff)
         CUT_BASS:   rule_hit = b_hit;
         CUT_TREBLE: rule_hit = t_hit;
         CUT_BOTH:   rule_hit = b_hit && t_hit;
         CUT_EITHER: rule_hit = b_hit || t_hit;
      endcase
   end

   assign cut_now = rule_hit && (!cut_seen_ff || elapsed >= {16'd0, cut_min_delay_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         cut_seen_ff <= 1'b0;
         last_cut_ff <= '0;
      end else if (cmd.finish && cut_now) begin
         cut_seen_ff <= 1'b1;
         last_cut_ff <= now_ff;
      end
   end

   // Output register, held until the response is taken
   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (cmd.finish)
         rsp_valid_ff <= 1'b1;
      else if (!rsp_stall)
         rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_strength_ff <= strength_ff;
         rsp_soft_ff     <= soft_ff;
         rsp_cut_ff      <= cut_now;
         rsp_bpm_ff      <= held_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_beat_strength = rsp_strength_ff;
   assign rsp_soft_beat     = rsp_soft_ff;
   assign rsp_hard_cut      = rsp_cut_ff;
   assign rsp_tempo_bpm     = rsp_bpm_ff;

   assign status.need_div  = !sum_zero && !sat;
   assign status.onset     = soft_ff;
   assign status.beat_any  = count_ff != '0;
   assign status.walk_last = ({1'b0, k_ff} + (CW + 1)'(2)) == {1'b0, count_ff};
   assign status.bpm_div   = n_ff != '0 && !bpm_sat;
   assign status.div_done  = div_done;
   assign status.out_free  = !rsp_valid_ff;

   // An onset always means a saturated strength
   a_soft_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_soft_ff |-> rsp_strength_ff == STRENGTH_ONE)
      else $error("soft beat without saturated strength");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILLW'(BASS_RING_DEPTH))
      else $error("bass ring fill count overflow");

   a_cut_recorded: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && cut_now |=> cut_seen_ff && last_cut_ff == $past(now_ff))
      else $error("hard cut not recorded");
endmodule

@@ hw/rtl/abod_ctrl.sv @@
// Sequencer that steps the datapath through one frame.
module abod_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  abod_pkg::abod_status_type status,
   output abod_pkg::abod_cmd_type    cmd
);
   import abod_pkg::*;

   abod_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= ST_IDLE;
      else
         state_ff <= state_in;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_UPDATE;
         ST_UPDATE:   state_in = ST_EVAL;
         ST_EVAL:     state_in = status.need_div ? ST_DIV_STR : ST_SOFT_CHK;
         ST_DIV_STR:  if (status.div_done) state_in = ST_SOFT_CHK;
         ST_SOFT_CHK: state_in = status.onset ? ST_BEAT_WR : ST_FINISH;
         ST_BEAT_WR:  state_in = status.beat_any ? ST_WALK : ST_FINISH;
         ST_WALK:     if (status.walk_last) state_in = ST_BPM_CHK;
         ST_BPM_CHK:  state_in = status.bpm_div ? ST_DIV_BPM : ST_FINISH;
         ST_DIV_BPM:  if (status.div_done) state_in = ST_FINISH;
         ST_FINISH:   if (status.out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_UPDATE:   cmd.update   = 1'b1;
         ST_EVAL:     cmd.eval     = 1'b1;
         ST_DIV_STR:  cmd.take_str = 1'b1;
         ST_SOFT_CHK: cmd          = '0;
         ST_BEAT_WR:  cmd.beat_wr  = 1'b1;
         ST_WALK:     cmd.walk     = 1'b1;
         ST_BPM_CHK:  cmd.bpm_chk  = 1'b1;
         ST_DIV_BPM:  cmd.take_bpm = 1'b1;
         ST_FINISH:   cmd.finish   = status.out_free;
         default:     cmd          = '0;
      endcase
   end
endmodule

@@ hw/rtl/audio_beat_onset_detector_top.sv @@
// Top level of the audio beat onset and hard cut detector.
// One frame is processed at a time and a new request is taken only when the
// sequencer is idle; the result waits in an output register, so the next frame
// may enter while it is still pending, and that frame waits in its last step
// until the register is free. A frame steps through update, evaluation, a
// soft beat check and finish, with the strength division after evaluation
// unless the strength saturates or is zero. A soft beat adds a step to store
// its timestamp; once an earlier beat is stored it adds a walk back over the
// stored intervals (up to BEAT_RING_DEPTH-1) of the timestamp ring, a tempo
// check, and the tempo division unless the tempo saturates or no interval
// counts. Both divisions run one quotient bit per cycle on a single shared
// divider. The bass history needs no clearing pass after reset. Register
// writes are taken in any cycle and should be issued only while no frame is
// in flight.
module audio_beat_onset_detector_top #(
   parameter int BASS_RING_DEPTH = 64,
   parameter int BEAT_RING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_bass_level,
   input  logic [15:0] req_treble_level,
   input  logic [15:0] req_bass_attenuated,
   input  logic [31:0] req_frame_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_beat_strength,
   output logic        rsp_soft_beat,
   output logic        rsp_hard_cut,
   output logic [15:0] rsp_tempo_bpm,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import abod_pkg::*;

   abod_cmd_type    cmd;
   abod_status_type status;

   // Registers accept a write in every cycle
   assign csr_ready = 1'b1;

   abod_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   abod_dp #(
      .BASS_RING_DEPTH (BASS_RING_DEPTH),
      .BEAT_RING_DEPTH (BEAT_RING_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_bass_level      (req_bass_level),
      .req_treble_level    (req_treble_level),
      .req_bass_attenuated (req_bass_attenuated),
      .req_frame_time_ms   (req_frame_time_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_beat_strength   (rsp_beat_strength),
      .rsp_soft_beat       (rsp_soft_beat),
      .rsp_hard_cut        (rsp_hard_cut),
      .rsp_tempo_bpm       (rsp_tempo_bpm),
      .csr_valid           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );
endmodule
